@@ sv/latest_valid_record_selector_top_defines.svh @@
// ----------------------------------------------------------------------------
// latest valid record selector - assertion macros
// shared concurrent assertion forms used by the scan logic
// ----------------------------------------------------------------------------
`ifndef LATEST_VALID_RECORD_SELECTOR_TOP_DEFINES_SVH
`define LATEST_VALID_RECORD_SELECTOR_TOP_DEFINES_SVH

// consequent checked in the same cycle as the antecedent
`define LVRS_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// consequent checked in the cycle after the antecedent
`define LVRS_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ sv/lvrs_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lvrs_pkg
// types, codes and the crc-32/mpeg-2 word update for the record selector
// ----------------------------------------------------------------------------
package lvrs_pkg;

    // opcodes of an input item
    typedef enum logic [2:0] {
        OP_MAGIC  = 3'd0,
        OP_INDEX  = 3'd1,
        OP_DATA   = 3'd2,
        OP_CRC    = 3'd3,
        OP_FINISH = 3'd4
    } t_opcode;

    // scan outcome codes
    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_EMPTY   = 2'd1,
        ST_CRC_BAD = 2'd2
    } t_status;

    // configuration register indexes
    typedef enum logic {
        CFG_PARAM_COUNT = 1'b0,
        CFG_MAGIC_VALUE = 1'b1
    } t_cfg_idx;

    localparam logic [8:0]  SLOTS_PER_PAGE    = 9'd16;
    localparam logic [6:0]  MAX_WORDS         = 7'd64;
    localparam logic [6:0]  PARAM_COUNT_RESET = 7'd16;
    localparam logic [31:0] ALL_ONES          = 32'hFFFF_FFFF;
    localparam logic [31:0] CRC_POLY          = 32'h04C1_1DB7;

    typedef struct packed {
        logic [2:0]  opcode;
        logic        page;
        logic [3:0]  slot;
        logic [31:0] word;
    } t_in_item;

    typedef struct packed {
        logic [1:0]  status;
        logic        best_page;
        logic [3:0]  best_slot;
        logic [31:0] best_index;
    } t_out_item;

    // msb-first crc over one 32-bit word, a pure xor network
    function automatic logic [31:0] crc32_word(input logic [31:0] crc, input logic [31:0] w);
        logic [31:0] c;
        c = crc ^ w;
        for (int b = 0; b < 32; b++) begin
            c = c[31] ? ((c << 1) ^ CRC_POLY) : (c << 1);
        end
        return c;
    endfunction

endpackage

@@ sv/lvrs_if.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lvrs_if
// valid/ready channel carrying one payload item
// ----------------------------------------------------------------------------
interface lvrs_if #(
    parameter type t_payload = logic
) ();
    logic     valid;
    logic     ready;
    t_payload payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

@@ sv/lvrs_in_reg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lvrs_in_reg
// input register stage, refilled in the cycle its item is consumed
// ----------------------------------------------------------------------------
module lvrs_in_reg (
    input  logic               i_clk,
    input  logic               i_rst_n,
    lvrs_if.sink               i_item,
    input  logic               i_advance,
    output logic               o_valid,
    output lvrs_pkg::t_in_item o_item
);
    logic               r_valid;
    lvrs_pkg::t_in_item r_item;
    logic               n_valid;
    logic               w_take;

    assign i_item.ready = !r_valid || i_advance;
    assign w_take       = i_item.valid && i_item.ready;

    always_comb begin
        n_valid = r_valid;
        if (w_take) begin
            n_valid = 1'b1;
        end else if (i_advance) begin
            n_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_take) begin
            r_item <= i_item.payload;
        end
    end

    assign o_valid = r_valid;
    assign o_item  = r_item;
endmodule

@@ sv/lvrs_scan.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lvrs_scan
// record scan state: crc check, newest-index selection and finish report
// ----------------------------------------------------------------------------
`include "latest_valid_record_selector_top_defines.svh"

module lvrs_scan (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_fire,
    input  lvrs_pkg::t_in_item  i_item,
    input  logic [6:0]          i_param_count,
    input  logic [31:0]         i_magic_value,
    output lvrs_pkg::t_out_item o_result
);
    logic [31:0] r_crc,          n_crc;
    logic        r_in_record,    n_in_record;
    logic [31:0] r_record_index, n_record_index;
    logic [6:0]  r_words_seen,   n_words_seen;
    logic [1:0]  r_page_stopped, n_page_stopped;
    logic        r_found_valid,  n_found_valid;
    logic        r_found_any,    n_found_any;
    logic [31:0] r_best_index,   n_best_index;
    logic        r_best_page,    n_best_page;
    logic [3:0]  r_best_slot,    n_best_slot;
    logic        r_rec_page,     n_rec_page;
    logic [3:0]  r_rec_slot,     n_rec_slot;

    logic [6:0]  w_needed;
    logic        w_active;

    assign w_needed = (i_param_count > lvrs_pkg::MAX_WORDS) ? lvrs_pkg::MAX_WORDS
                                                           : i_param_count;
    assign w_active = i_fire && !r_page_stopped[i_item.page]
                      && ({5'd0, i_item.slot} < lvrs_pkg::SLOTS_PER_PAGE);

    always_comb begin
        n_crc          = r_crc;
        n_in_record    = r_in_record;
        n_record_index = r_record_index;
        n_words_seen   = r_words_seen;
        n_page_stopped = r_page_stopped;
        n_found_valid  = r_found_valid;
        n_found_any    = r_found_any;
        n_best_index   = r_best_index;
        n_best_page    = r_best_page;
        n_best_slot    = r_best_slot;
        n_rec_page     = r_rec_page;
        n_rec_slot     = r_rec_slot;
        case (i_item.opcode)
            lvrs_pkg::OP_FINISH: begin
                if (i_fire) begin
                    n_in_record    = 1'b0;
                    n_page_stopped = 2'b00;
                    n_found_valid  = 1'b0;
                    n_found_any    = 1'b0;
                end
            end
            lvrs_pkg::OP_MAGIC: begin
                if (w_active) begin
                    if (i_item.word == lvrs_pkg::ALL_ONES) begin
                        n_page_stopped[i_item.page] = 1'b1;
                        n_in_record                 = 1'b0;
                    end else if (i_item.word == i_magic_value) begin
                        n_found_any    = 1'b1;
                        n_in_record    = 1'b1;
                        n_crc          = lvrs_pkg::ALL_ONES;
                        n_words_seen   = 7'd0;
                        n_record_index = 32'd0;
                        n_rec_page     = i_item.page;
                        n_rec_slot     = i_item.slot;
                    end else begin
                        n_in_record = 1'b0;
                    end
                end
            end
            lvrs_pkg::OP_INDEX: begin
                if (w_active && r_in_record) begin
                    n_record_index = i_item.word;
                end
            end
            lvrs_pkg::OP_DATA: begin
                if (w_active && r_in_record && (r_words_seen < w_needed)) begin
                    n_crc        = lvrs_pkg::crc32_word(r_crc, i_item.word);
                    n_words_seen = r_words_seen + 7'd1;
                end
            end
            lvrs_pkg::OP_CRC: begin
                if (w_active && r_in_record) begin
                    // short records and bad crcs just close the record
                    if ((r_words_seen >= w_needed) && (r_crc == i_item.word)
                        && (!r_found_valid || (r_record_index > r_best_index))) begin
                        n_found_valid = 1'b1;
                        n_best_index  = r_record_index;
                        n_best_page   = r_rec_page;
                        n_best_slot   = r_rec_slot;
                    end
                    n_in_record = 1'b0;
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_record    <= 1'b0;
            r_page_stopped <= 2'b00;
            r_found_valid  <= 1'b0;
            r_found_any    <= 1'b0;
        end else begin
            r_in_record    <= n_in_record;
            r_page_stopped <= n_page_stopped;
            r_found_valid  <= n_found_valid;
            r_found_any    <= n_found_any;
        end
    end

    always_ff @(posedge i_clk) begin
        r_crc          <= n_crc;
        r_record_index <= n_record_index;
        r_words_seen   <= n_words_seen;
        r_best_index   <= n_best_index;
        r_best_page    <= n_best_page;
        r_best_slot    <= n_best_slot;
        r_rec_page     <= n_rec_page;
        r_rec_slot     <= n_rec_slot;
    end

    // finish report, taken from the state before this item
    always_comb begin
        o_result = '0;
        if (r_found_valid) begin
            o_result.status     = lvrs_pkg::ST_OK;
            o_result.best_page  = r_best_page;
            o_result.best_slot  = r_best_slot;
            o_result.best_index = r_best_index;
        end else if (r_found_any) begin
            o_result.status = lvrs_pkg::ST_CRC_BAD;
        end else begin
            o_result.status = lvrs_pkg::ST_EMPTY;
        end
    end

    `LVRS_ASSERT_NOW(a_valid_needs_any, i_clk, i_rst_n, r_found_valid, r_found_any, "winner without any record")
    `LVRS_ASSERT_NOW(a_open_needs_any, i_clk, i_rst_n, r_in_record, r_found_any, "open record without magic")
    `LVRS_ASSERT_NEXT(a_finish_clears, i_clk, i_rst_n, i_fire && (i_item.opcode == lvrs_pkg::OP_FINISH), !r_found_valid && !r_found_any && !r_in_record && (r_page_stopped == 2'b00), "scan state not cleared after finish")
endmodule

@@ sv/lvrs_out_reg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lvrs_out_reg
// result register holding the finish report until it is taken
// ----------------------------------------------------------------------------
module lvrs_out_reg (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_load,
    input  lvrs_pkg::t_out_item i_result,
    output logic                o_can_load,
    lvrs_if.source              o_result
);
    logic                r_valid;
    logic                n_valid;
    lvrs_pkg::t_out_item r_result;

    assign o_can_load = !r_valid || o_result.ready;

    always_comb begin
        n_valid = r_valid;
        if (i_load) begin
            n_valid = 1'b1;
        end else if (o_result.ready) begin
            n_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_result <= i_result;
        end
    end

    assign o_result.valid   = r_valid;
    assign o_result.payload = r_result;
endmodule

@@ sv/latest_valid_record_selector_top.sv @@
// a finish item's report is loaded from the scan state into the result register and shown on o_result
// throughput: one item per cycle; the one-cycle crc xor network sets the pace
// a finish item stalls only while the result register is full and o_result.ready is low
// reset: synchronous, active low; clears the scan state and both channels,
// loads param_count with 16 and magic_value with 0; there is no clearing pass
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// latest_valid_record_selector_top
// scans a two-page record log and reports the newest record with a good crc
// ----------------------------------------------------------------------------
module latest_valid_record_selector_top (
    input  logic        i_clk,
    input  logic        i_rst_n,
    lvrs_if.sink        i_item,
    lvrs_if.source      o_result,
    input  logic        i_cfg_we,
    input  logic        i_cfg_idx,
    input  logic [31:0] i_cfg_data
);
    // configuration registers, to be written only while the block is idle; the block does not enforce this
    logic [6:0]  r_param_count;
    logic [31:0] r_magic_value;

    // input stage
    logic               w_in_valid;
    lvrs_pkg::t_in_item w_in_item;

    // handshake between the stages
    logic w_is_finish;
    logic w_can_load;
    logic w_advance;

    // finish report from the scan state
    lvrs_pkg::t_out_item w_result;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_param_count <= lvrs_pkg::PARAM_COUNT_RESET;
            r_magic_value <= 32'd0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                lvrs_pkg::CFG_PARAM_COUNT: r_param_count <= i_cfg_data[6:0];
                lvrs_pkg::CFG_MAGIC_VALUE: r_magic_value <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    // item held in the input register
    lvrs_in_reg u_in_reg (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_item    (i_item),
        .i_advance (w_advance),
        .o_valid   (w_in_valid),
        .o_item    (w_in_item)
    );

    // only a finish item needs room in the result register
    assign w_is_finish = (w_in_item.opcode == lvrs_pkg::OP_FINISH);
    assign w_advance   = w_in_valid && (!w_is_finish || w_can_load);

    // crc check and newest-record selection, one item per cycle while no finish item stalls
    lvrs_scan u_scan (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_fire        (w_advance),
        .i_item        (w_in_item),
        .i_param_count (r_param_count),
        .i_magic_value (r_magic_value),
        .o_result      (w_result)
    );

    // result register decouples the downstream stall from the scan
    lvrs_out_reg u_out_reg (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_load     (w_advance && w_is_finish),
        .i_result   (w_result),
        .o_can_load (w_can_load),
        .o_result   (o_result)
    );
endmodule
